>>> rtl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks, clocked on clk and held off in reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/sbpf_pkg.sv
//------------------------------------------------------------------------------
// Spectrum bar peak/fall package
// Types, constants and register codes shared by the spectrum bar block.
//------------------------------------------------------------------------------
package sbpf_pkg;

  localparam int COLUMNS = 32;
  localparam int SLOTS   = COLUMNS * 3;
  localparam int SLOT_W  = $clog2(SLOTS);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_SCALE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PEAKS_ENABLE = 1'd1;

  localparam logic [8:0] LEVEL_SCALE_RST = 9'd224;
  localparam logic       PEAKS_EN_RST    = 1'b1;

  localparam logic [1:0] CH_LEFT  = 2'd0;
  localparam logic [1:0] CH_RIGHT = 2'd1;
  localparam logic [1:0] CH_BOTH  = 2'd2;

  typedef struct packed {
    logic [4:0] column;
    logic [1:0] channel;
    logic [7:0] raw_left;
    logic [7:0] raw_right;
    logic       clear_store;
  } in_item_t;

  typedef struct packed {
    logic [4:0] column_out;
    logic [7:0] scaled_level;
    logic [7:0] shown_level;
    logic [7:0] previous_level;
    logic [8:0] peak_level;
  } out_item_t;

  // One column/channel entry of the bar store.
  typedef struct packed {
    logic [7:0] shown;
    logic [8:0] peak;
    logic [8:0] fall;
  } entry_t;

endpackage

>>> rtl/spectrum_bar_peak_fall.sv
//------------------------------------------------------------------------------
// Spectrum bar peak/fall
// Spectrum bar animation with peak hold and accelerating fall. A request names one column,
// a channel (left, right, or both as the larger level) and the raw levels. Each request
// gives one result through the update stage and then the result register. A new request
// is taken every cycle unless a result is waiting on out_ready. The per-column state sits
// in a memory with one write port and one read port, read at acceptance. A request that
// hits the entry written in the same cycle gets that data forwarded. The level multiply
// and the update logic share one stage. A request with clear_store set drops all stored
// state before it is handled.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_bar_peak_fall (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sbpf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbpf_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sbpf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sbpf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sbpf_pkg::*;

  logic [8:0]        level_scale_r;
  logic              peaks_en_r;

  entry_t            mem [SLOTS];
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  valid_nxt;

  logic              s1_valid_r;
  in_item_t          s1_data_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_inside_r;
  logic              rd_valid_r;
  logic              fwd_r;
  entry_t            fwd_data_r;
  entry_t            mem_rd_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_fire;
  logic              s1_adv;
  logic              wr_en;
  logic [1:0]        in_chan_slot;
  logic              in_inside;
  logic [SLOT_W-1:0] in_slot;
  logic              fwd_hit;

  entry_t            cur;
  entry_t            new_entry;
  logic [7:0]        raw;
  logic [16:0]       prod;
  logic [7:0]        level;
  logic [7:0]        show_fall;
  logic [8:0]        fall_fall;
  logic [7:0]        show_new;
  logic [8:0]        fall_new;
  logic [8:0]        peak_new;
  out_item_t         result;

  // Handshake and pipeline advance.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_adv && s1_inside_r;

  // Entry address of the incoming request.
  always_comb begin
    case (in_data.channel)
      CH_LEFT:  in_chan_slot = CH_LEFT;
      CH_RIGHT: in_chan_slot = CH_RIGHT;
      default:  in_chan_slot = CH_BOTH;
    endcase
  end

  assign in_inside = int'(in_data.column) < COLUMNS;
  assign in_slot   = in_inside ? (SLOT_W'({in_data.column, 1'b0}) + SLOT_W'(in_data.column)
                                  + SLOT_W'(in_chan_slot))
                               : '0;
  assign fwd_hit   = wr_en && (in_slot == s1_slot_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_scale_r <= LEVEL_SCALE_RST;
      peaks_en_r    <= PEAKS_EN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEVEL_SCALE:  level_scale_r <= cfg_wdata;
        REG_PEAKS_ENABLE: peaks_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Entry store.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= mem[in_slot];
    end
    if (wr_en) begin
      mem[s1_slot_r] <= new_entry;
    end
  end

  // A clear arriving with a write in the same cycle comes later in order, so it wins.
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[s1_slot_r] = 1'b1;
    end
    if (in_fire && in_data.clear_store) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Update stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r   <= in_data;
      s1_slot_r   <= in_slot;
      s1_inside_r <= in_inside;
      rd_valid_r  <= in_inside && !in_data.clear_store && (fwd_hit || valid_r[in_slot]);
      fwd_r       <= fwd_hit;
      fwd_data_r  <= new_entry;
    end
  end

  // Bar and peak update.
  always_comb begin
    if (!rd_valid_r) begin
      cur = '0;
    end else if (fwd_r) begin
      cur = fwd_data_r;
    end else begin
      cur = mem_rd_r;
    end

    case (s1_data_r.channel)
      CH_LEFT:  raw = s1_data_r.raw_left;
      CH_RIGHT: raw = s1_data_r.raw_right;
      default:  raw = (s1_data_r.raw_left > s1_data_r.raw_right) ? s1_data_r.raw_left
                                                                  : s1_data_r.raw_right;
    endcase

    prod  = 17'(level_scale_r) * 17'(raw);
    level = (prod[16:8] > 9'd255) ? 8'd255 : prod[15:8];

    show_fall = cur.shown;
    fall_fall = cur.fall;
    if (level < cur.shown) begin
      if ({1'b0, cur.shown} >= cur.fall) begin
        show_fall = 8'({1'b0, cur.shown} - cur.fall);
        if (cur.fall != 9'h1FF) begin
          fall_fall = cur.fall + 9'd1;
        end
      end else begin
        show_fall = 8'd0;
      end
    end

    show_new = show_fall;
    fall_new = fall_fall;
    if (level > show_fall) begin
      show_new = level;
      fall_new = 9'd1;
    end

    peak_new = cur.peak;
    if (cur.peak <= {1'b0, level}) begin
      peak_new = {1'b0, level} + 9'd1;
    end else if (cur.peak != 9'd0 && cur.peak > ({1'b0, show_new} + 9'd1)) begin
      peak_new = cur.peak - 9'd1;
    end

    new_entry.shown = show_new;
    new_entry.peak  = peak_new;
    new_entry.fall  = fall_new;

    result.column_out     = s1_data_r.column;
    result.scaled_level   = level;
    result.shown_level    = show_new;
    result.previous_level = cur.shown;
    result.peak_level     = peaks_en_r ? peak_new : 9'd0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_clear_drops_all, in_fire && in_data.clear_store, valid_r == '0)
  `ASSERT_IMPLIES(a_bar_not_below_level, out_valid_r,
                  out_data_r.shown_level >= out_data_r.scaled_level)
  `ASSERT_IMPLIES(a_ready_when_drained, !out_valid_r, in_ready)

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Spectrum bar peak/fall testbench
// Streams column requests through the bar animation block with random gaps and
// stalls on both channels, predicts every result from its own copy of the bar
// store, and compares each result as it leaves the block. Runs through several
// scale and peak settings, written between phases while the block is idle.
//------------------------------------------------------------------------------
module tb;
  import sbpf_pkg::*;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          LONG_HOLD    = 300;
  localparam int          TAIL_CYCLES  = 10;
  localparam int          MAX_PRINTED  = 50;
  localparam int          IN_W         = $bits(in_item_t);
  // The block treats the unused channel code like "both".
  localparam logic [1:0]  CH_BOTH_ALT  = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spectrum_bar_peak_fall DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bar store mirror and register copies.
  logic [7:0] bar_shown [SLOTS];
  logic [8:0] bar_peak  [SLOTS];
  logic [8:0] bar_fall  [SLOTS];
  logic       bar_valid [SLOTS];
  logic [8:0] scale_cfg = LEVEL_SCALE_RST;
  logic       peaks_cfg = PEAKS_EN_RST;

  in_item_t    pending_reqs  [$];
  out_item_t   expected_bars [$];
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned ready_hold     = 0;
  bit          gaps_on        = 1'b1;
  bit          long_hold_arm  = 1'b0;
  bit          long_hold_done = 1'b0;

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Applies one request to the mirror store and returns the bar it should show.
  function automatic out_item_t bar_update(input in_item_t req);
    out_item_t   res;
    int unsigned raw, lvl, show, peak, fall, prev, slot, lane;
    bit          hit;
    if (req.clear_store) begin
      foreach (bar_valid[i]) bar_valid[i] = 1'b0;
    end
    case (req.channel)
      CH_LEFT: begin
        lane = 0;
        raw  = 32'(req.raw_left);
      end
      CH_RIGHT: begin
        lane = 1;
        raw  = 32'(req.raw_right);
      end
      default: begin
        lane = 2;
        raw  = (req.raw_left > req.raw_right) ? 32'(req.raw_left) : 32'(req.raw_right);
      end
    endcase
    lvl = (scale_cfg * raw) >> 8;
    if (lvl > 255) lvl = 255;
    hit  = req.column < COLUMNS;
    slot = hit ? req.column * 3 + lane : 0;
    show = 0;
    peak = 0;
    fall = 0;
    if (hit && bar_valid[slot]) begin
      show = 32'(bar_shown[slot]);
      peak = 32'(bar_peak[slot]);
      fall = 32'(bar_fall[slot]);
    end
    prev = show;
    // Falling bars drop by a speed that grows per step up to 511; a bar below the speed drops to zero.
    if (lvl < show) begin
      if (show >= fall) begin
        show -= fall;
        if (fall < 511) fall++;
      end else begin
        show = 0;
      end
    end
    if (lvl > show) begin
      show = lvl;
      fall = 1;
    end
    if (peak <= lvl) begin
      peak = lvl + 1;
    end else if (peak != 0 && peak > show + 1) begin
      peak--;
    end
    if (hit) begin
      bar_shown[slot] = show[7:0];
      bar_peak[slot]  = peak[8:0];
      bar_fall[slot]  = fall[8:0];
      bar_valid[slot] = 1'b1;
    end
    res.column_out     = req.column;
    res.scaled_level   = lvl[7:0];
    res.shown_level    = show[7:0];
    res.previous_level = prev[7:0];
    res.peak_level     = peaks_cfg ? peak[8:0] : 9'd0;
    return res;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_bars.push_back(bar_update(in_data));
        accepted_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          if (gaps_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 13);
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = pending_reqs.pop_front();
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    logic      nxt_ready;
    out_item_t want;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bars.size() == 0) begin
          report_error($sformatf("result for column %0d with no request outstanding",
                                 out_data.column_out));
        end else begin
          want = expected_bars.pop_front();
          if (out_data !== want) begin
            report_error($sformatf(
              "col %0d/%0d scaled %0d/%0d shown %0d/%0d prev %0d/%0d peak %0d/%0d (got/want)",
              out_data.column_out, want.column_out, out_data.scaled_level, want.scaled_level,
              out_data.shown_level, want.shown_level, out_data.previous_level,
              want.previous_level, out_data.peak_level, want.peak_level));
          end
        end
      end
      // One long hold-off once a result is waiting, so the pipeline backs up.
      if (long_hold_arm && !long_hold_done && out_valid) begin
        long_hold_done = 1'b1;
        ready_hold     = LONG_HOLD;
      end
      if (ready_hold != 0) begin
        ready_hold--;
        nxt_ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(0, 13);
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic in_item_t mk_req(input int col, input logic [1:0] ch, input int left,
                                      input int right, input bit clr);
    in_item_t r;
    r.column      = 5'(col);
    r.channel     = ch;
    r.raw_left    = 8'(left);
    r.raw_right   = 8'(right);
    r.clear_store = clr;
    return r;
  endfunction

  task automatic queue_req(input in_item_t r);
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_LEVEL_SCALE) scale_cfg = val;
    else peaks_cfg = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || accepted_count != queued_count ||
           expected_bars.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Mostly runs on one entry: a rise followed by a decay, so fall speed and
  // peak decay build up; the rest is unrelated requests.
  task automatic queue_random(input int n);
    in_item_t r;
    int       k, lvl;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) < 7) begin
        r.column  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 3));
        r.channel = 2'($urandom_range(0, 3));
        lvl       = $urandom_range(0, 255);
        repeat ($urandom_range(3, 12)) begin
          r.raw_left  = 8'($urandom);
          r.raw_right = 8'($urandom);
          case (r.channel)
            CH_LEFT:  r.raw_left  = 8'(lvl);
            CH_RIGHT: r.raw_right = 8'(lvl);
            default: begin
              if ($urandom_range(0, 1) == 0) begin
                r.raw_left  = 8'(lvl);
                r.raw_right = 8'($urandom_range(0, lvl));
              end else begin
                r.raw_right = 8'(lvl);
                r.raw_left  = 8'($urandom_range(0, lvl));
              end
            end
          endcase
          r.clear_store = ($urandom_range(0, 63) == 0);
          queue_req(r);
          k++;
          lvl = lvl - $urandom_range(0, lvl / 3 + 1);
          if (lvl < 0) lvl = 0;
          if ($urandom_range(0, 5) == 0) lvl = $urandom_range(0, 255);
        end
      end else begin
        r             = in_item_t'(IN_W'($urandom));
        r.clear_store = ($urandom_range(0, 31) == 0);
        queue_req(r);
        k++;
      end
    end
  endtask

  task automatic run_phase(input int scale, input bit peaks, input int n);
    write_reg(REG_LEVEL_SCALE, CFG_DATA_W'(scale));
    write_reg(REG_PEAKS_ENABLE, CFG_DATA_W'(peaks));
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    foreach (bar_valid[i]) begin
      bar_shown[i] = '0;
      bar_peak[i]  = '0;
      bar_fall[i]  = '0;
      bar_valid[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset settings.
    queue_req(mk_req(0, CH_LEFT, 255, 0, 0));
    repeat (6) queue_req(mk_req(0, CH_LEFT, 0, 255, 0));
    queue_req(mk_req(31, CH_RIGHT, 0, 255, 0));
    queue_req(mk_req(31, CH_RIGHT, 255, 0, 0));
    queue_req(mk_req(31, CH_BOTH, 200, 100, 0));
    queue_req(mk_req(31, CH_BOTH, 100, 200, 0));
    queue_req(mk_req(31, CH_BOTH_ALT, 7, 255, 0));
    queue_req(mk_req(5, CH_BOTH_ALT, 255, 0, 0));
    queue_req(mk_req(0, CH_LEFT, 128, 0, 1));
    queue_req(mk_req(0, CH_LEFT, 0, 0, 0));
    queue_req(mk_req(31, CH_BOTH, 0, 0, 0));
    queue_req(mk_req(17, CH_RIGHT, 170, 85, 0));
    queue_req(mk_req(10, CH_LEFT, 85, 170, 1));
    queue_req(mk_req(10, CH_LEFT, 85, 170, 0));
    wait_drained();

    run_phase(511, 1'b1, 100);
    run_phase(0, 1'b0, 60);
    long_hold_arm = 1'b1;
    run_phase(256, 1'b1, 120);
    run_phase(1, 1'b1, 80);
    run_phase(int'($urandom_range(0, 511)), 1'b0, 120);
    gaps_on = 1'b0;
    run_phase(int'(LEVEL_SCALE_RST), 1'b1, 100);
    gaps_on = 1'b1;
    run_phase(int'($urandom_range(0, 511)), 1'b1, 120);
    // Final stretch runs at full rate on both sides.
    gaps_on = 1'b0;
    run_phase(256, 1'b0, 100);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
